>>> rtl/core/sharpen_stencil_rgb_core_macros.svh
// Assertion macros shared by the sharpen stencil core RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SHARPEN_STENCIL_RGB_CORE_MACROS_SVH
`define SHARPEN_STENCIL_RGB_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sharpen core check failed");

// Next-cycle implication, disabled while in reset.
`define SSCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sharpen core check failed");

`endif

>>> rtl/core/sscr_pkg.sv
// Shared types and constants for the five-point sharpen core.
// No dependencies; used by the interfaces, the filter datapath and the top level.
`timescale 1ns / 1ps

package sscr_pkg;

	localparam int MAX_WIDTH        = 2048;
	localparam int WEIGHT_FRAC_BITS = 12;
	localparam int LINE_AW          = $clog2(MAX_WIDTH);

	localparam int PIX_W    = 24;
	localparam int CH_W     = 8;
	localparam int NUM_CH   = 3;
	localparam int WEIGHT_W = 16;
	localparam int NSUM_W   = CH_W + 2;
	localparam int ACC_W    = WEIGHT_W + NSUM_W + 1;

	localparam int COL_W   = 11;
	localparam int ROW_W   = 12;
	localparam int WIDTH_W = 12;

	localparam logic [ROW_W-1:0]   ROW_MAX   = ROW_W'(4095);
	localparam logic [WIDTH_W-1:0] MIN_WIDTH = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0] MAX_EFF_W = WIDTH_W'(MAX_WIDTH);
	localparam logic [CH_W-1:0]    ALPHA     = 8'hff;

	// APB register map, word index = paddr[3:2]
	localparam int PADDR_W   = 4;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_WEIGHT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NEIGHBOR_WEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH    = 2'd2;

	localparam logic [WEIGHT_W-1:0] CENTER_WEIGHT_RST   = 16'sd20480;
	localparam logic [WEIGHT_W-1:0] NEIGHBOR_WEIGHT_RST = 16'hf000;
	localparam logic [WIDTH_W-1:0]  ACTIVE_WIDTH_RST    = 12'd1024;

	// Stencil samples for one centre pixel, index 2 = red, 1 = green, 0 = blue
	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0]   ctr;
		logic [NUM_CH-1:0][NSUM_W-1:0] nsum;
		logic [COL_W-1:0]              col;
		logic [ROW_W-1:0]              row;
	} sample_t;

endpackage

>>> rtl/core/sscr_stream_if.sv
// Valid/ready stream interfaces for pixels in and sharpened pixels out.
// Depends on sscr_pkg for field widths.
`timescale 1ns / 1ps

interface sscr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;
	logic        frame_start;

	modport source (output valid, output pixel_word, output frame_start, input ready);
	modport sink   (input valid, input pixel_word, input frame_start, output ready);
endinterface

interface sscr_out_if;
	logic                        valid;
	logic                        ready;
	logic [31:0]                 result_word;
	logic [sscr_pkg::COL_W-1:0]  out_col;
	logic [sscr_pkg::ROW_W-1:0]  out_row;

	modport source (output valid, output result_word, output out_col, output out_row,
		input ready);
	modport sink   (input valid, input result_word, input out_col, input out_row,
		output ready);
endinterface

>>> rtl/core/sscr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when the same address is written in that cycle.
`timescale 1ns / 1ps

module sscr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/sscr_filter.sv
// Sharpen arithmetic: sample register, weight multiplies, shift/clamp, output register.
// Depends on sscr_pkg, sscr_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "sharpen_stencil_rgb_core_macros.svh"

module sscr_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_valid,
	output logic                                 s_ready,
	input  sscr_pkg::sample_t                    s_data,
	input  logic [sscr_pkg::WEIGHT_W-1:0]        center_weight,
	input  logic [sscr_pkg::WEIGHT_W-1:0]        neighbor_weight,
	sscr_out_if.source                           pix_out
);

	function automatic logic [sscr_pkg::CH_W-1:0] clamp_px(
		input logic signed [sscr_pkg::ACC_W-1:0] acc
	);
		logic signed [sscr_pkg::ACC_W-1:0] sh;
		sh = acc >>> sscr_pkg::WEIGHT_FRAC_BITS;
		if (acc < 0) begin
			return '0;
		end else if (|sh[sscr_pkg::ACC_W-1:sscr_pkg::CH_W]) begin
			return '1;
		end else begin
			return sh[sscr_pkg::CH_W-1:0];
		end
	endfunction

	logic                                    v_s2, v_s3, out_valid_q;
	sscr_pkg::sample_t                       smp_s2;
	logic signed [sscr_pkg::ACC_W-1:0]       pc_s3 [sscr_pkg::NUM_CH];
	logic signed [sscr_pkg::ACC_W-1:0]       pn_s3 [sscr_pkg::NUM_CH];
	logic [sscr_pkg::COL_W-1:0]              col_s3, col_q;
	logic [sscr_pkg::ROW_W-1:0]              row_s3, row_q;
	logic [sscr_pkg::NUM_CH-1:0][sscr_pkg::CH_W-1:0] px_q;
	logic                                    out_free, rdy_s3, load_s3, load_out;
	logic signed [sscr_pkg::ACC_W-1:0]       cw_x, nw_x;

	assign out_free = !out_valid_q || pix_out.ready;
	assign rdy_s3   = !v_s3 || out_free;
	assign s_ready  = !v_s2 || rdy_s3;
	assign load_s3  = v_s2 && rdy_s3;
	assign load_out = v_s3 && out_free;

	assign cw_x = $signed({{(sscr_pkg::ACC_W-sscr_pkg::WEIGHT_W){center_weight[15]}},
		center_weight});
	assign nw_x = $signed({{(sscr_pkg::ACC_W-sscr_pkg::WEIGHT_W){neighbor_weight[15]}},
		neighbor_weight});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_valid && s_ready) begin
				v_s2 <= 1'b1;
			end else if (load_s3) begin
				v_s2 <= 1'b0;
			end
			if (load_s3) begin
				v_s3 <= 1'b1;
			end else if (load_out) begin
				v_s3 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			smp_s2 <= s_data;
		end
		if (load_s3) begin
			for (int i = 0; i < sscr_pkg::NUM_CH; i++) begin
				pc_s3[i] <= cw_x * $signed({{(sscr_pkg::ACC_W-sscr_pkg::CH_W){1'b0}},
					smp_s2.ctr[i]});
				pn_s3[i] <= nw_x * $signed({{(sscr_pkg::ACC_W-sscr_pkg::NSUM_W){1'b0}},
					smp_s2.nsum[i]});
			end
			col_s3 <= smp_s2.col;
			row_s3 <= smp_s2.row;
		end
		if (load_out) begin
			for (int i = 0; i < sscr_pkg::NUM_CH; i++) begin
				px_q[i] <= clamp_px(pc_s3[i] + pn_s3[i]);
			end
			col_q <= col_s3;
			row_q <= row_s3;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.result_word = {px_q, sscr_pkg::ALPHA};
	assign pix_out.out_col     = col_q;
	assign pix_out.out_row     = row_q;

	`SSCR_ASSERT_NOW(a_out_interior, out_valid_q, (col_q != '0) && (row_q != '0))
	`SSCR_ASSERT_NEXT(a_s3_held, v_s3 && !out_free, v_s3 && $stable(col_s3))
	`SSCR_ASSERT_NEXT(a_s2_held, v_s2 && !rdy_s3, v_s2 && $stable(smp_s2))

endmodule

>>> rtl/core/sharpen_stencil_rgb_core.sv
// Channel     | dir | handshake        | payload
// pix_in      | in  | valid/ready      | pixel_word[31:0], frame_start
// pix_out     | out | valid/ready      | result_word[31:0], out_col[10:0], out_row[11:0]
// apb         | in  | psel/penable     | paddr[3:0], pwdata/prdata[31:0], pready tied high
//
// One pixel per clock sustained while pix_out is not stalled; a result reaches the output
// register through the line memory read, sample, multiply and clamp stages.
// Two 2048x24 line memories (previous line, line before it) are read and rewritten per
// pixel; no clearing pass after reset, so pixels are taken from the first cycle.
// pix_in.ready drops only when the output register is held and every stage behind it is full.
// Depends on sscr_pkg, sscr_stream_if, sscr_ram, sscr_filter and the macro header.
`timescale 1ns / 1ps
`include "sharpen_stencil_rgb_core_macros.svh"

module sharpen_stencil_rgb_core (
	input  logic                           clk,
	input  logic                           arst_n,
	sscr_in_if.sink                        pix_in,
	sscr_out_if.source                     pix_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sscr_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	// configuration registers
	logic [sscr_pkg::WEIGHT_W-1:0] center_weight_q, neighbor_weight_q;
	logic [sscr_pkg::WIDTH_W-1:0]  active_width_q, eff_w;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_weight_q   <= sscr_pkg::CENTER_WEIGHT_RST;
			neighbor_weight_q <= sscr_pkg::NEIGHBOR_WEIGHT_RST;
			active_width_q    <= sscr_pkg::ACTIVE_WIDTH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sscr_pkg::REG_CENTER_WEIGHT: begin
					center_weight_q <= pwdata[sscr_pkg::WEIGHT_W-1:0];
				end
				sscr_pkg::REG_NEIGHBOR_WEIGHT: begin
					neighbor_weight_q <= pwdata[sscr_pkg::WEIGHT_W-1:0];
				end
				sscr_pkg::REG_ACTIVE_WIDTH: begin
					active_width_q <= pwdata[sscr_pkg::WIDTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sscr_pkg::REG_CENTER_WEIGHT:   prdata = 32'(center_weight_q);
			sscr_pkg::REG_NEIGHBOR_WEIGHT: prdata = 32'(neighbor_weight_q);
			sscr_pkg::REG_ACTIVE_WIDTH:    prdata = 32'(active_width_q);
			default:                       prdata = '0;
		endcase
	end

	always_comb begin
		if (active_width_q < sscr_pkg::MIN_WIDTH) begin
			eff_w = sscr_pkg::MIN_WIDTH;
		end else if (active_width_q > sscr_pkg::MAX_EFF_W) begin
			eff_w = sscr_pkg::MAX_EFF_W;
		end else begin
			eff_w = active_width_q;
		end
	end

	// position counters and accept stage
	logic [sscr_pkg::COL_W-1:0] col_q, c_acc, c_s1;
	logic [sscr_pkg::ROW_W-1:0] row_q, r_acc, r_s1;
	logic [sscr_pkg::WIDTH_W-1:0] c_inc;
	logic accept, adv1, v_s1, emit_s1, fwd_s1, s_ready;
	logic [sscr_pkg::PIX_W-1:0] px_s1, fwd_px_s1, fwd_up1_s1;
	logic [sscr_pkg::PIX_W-1:0] up1_ram, up2_ram, up1, up2;

	assign c_acc = pix_in.frame_start ? '0 : col_q;
	assign r_acc = pix_in.frame_start ? '0 : row_q;
	assign c_inc = sscr_pkg::WIDTH_W'(c_acc) + 1'b1;

	assign adv1         = v_s1 && (!emit_s1 || s_ready);
	assign pix_in.ready = !v_s1 || adv1;
	assign accept       = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (accept) begin
				v_s1    <= 1'b1;
				emit_s1 <= (r_acc >= sscr_pkg::ROW_W'(2)) && (c_acc >= sscr_pkg::COL_W'(2));
				// same column written by the leaving pixel this edge: memory read is stale
				fwd_s1  <= adv1 && (c_acc == c_s1);
				if (c_inc >= eff_w) begin
					col_q <= '0;
					row_q <= (r_acc == sscr_pkg::ROW_MAX) ? r_acc : r_acc + 1'b1;
				end else begin
					col_q <= c_inc[sscr_pkg::COL_W-1:0];
					row_q <= r_acc;
				end
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= pix_in.pixel_word[31:8];
			c_s1       <= c_acc;
			r_s1       <= r_acc;
			fwd_px_s1  <= px_s1;
			fwd_up1_s1 <= up1;
		end
	end

	// line memories: lb1 holds the previous line, lb2 the one before
	sscr_ram #(.WIDTH(sscr_pkg::PIX_W), .DEPTH(sscr_pkg::MAX_WIDTH)) u_lb1 (
		.clk   (clk),
		.we    (adv1),
		.waddr (c_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (c_acc),
		.rdata (up1_ram)
	);

	sscr_ram #(.WIDTH(sscr_pkg::PIX_W), .DEPTH(sscr_pkg::MAX_WIDTH)) u_lb2 (
		.clk   (clk),
		.we    (adv1),
		.waddr (c_s1),
		.wdata (up1),
		.re    (accept),
		.raddr (c_acc),
		.rdata (up2_ram)
	);

	assign up1 = fwd_s1 ? fwd_px_s1  : up1_ram;
	assign up2 = fwd_s1 ? fwd_up1_s1 : up2_ram;

	// window: last column (top/mid/bot) plus the middle sample one column earlier
	logic [sscr_pkg::PIX_W-1:0] top_q, mid_q, bot_q, left_q;
	sscr_pkg::sample_t smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			mid_q  <= '0;
			bot_q  <= '0;
			left_q <= '0;
		end else if (adv1) begin
			top_q  <= up2;
			mid_q  <= up1;
			bot_q  <= px_s1;
			left_q <= mid_q;
		end
	end

	always_comb begin
		for (int i = 0; i < sscr_pkg::NUM_CH; i++) begin
			smp.ctr[i]  = mid_q[i*sscr_pkg::CH_W +: sscr_pkg::CH_W];
			smp.nsum[i] = sscr_pkg::NSUM_W'(top_q[i*sscr_pkg::CH_W +: sscr_pkg::CH_W])
				+ sscr_pkg::NSUM_W'(bot_q[i*sscr_pkg::CH_W +: sscr_pkg::CH_W])
				+ sscr_pkg::NSUM_W'(left_q[i*sscr_pkg::CH_W +: sscr_pkg::CH_W])
				+ sscr_pkg::NSUM_W'(up1[i*sscr_pkg::CH_W +: sscr_pkg::CH_W]);
		end
		smp.col = c_s1 - 1'b1;
		smp.row = r_s1 - 1'b1;
	end

	sscr_filter u_filter (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_valid         (v_s1 && emit_s1),
		.s_ready         (s_ready),
		.s_data          (smp),
		.center_weight   (center_weight_q),
		.neighbor_weight (neighbor_weight_q),
		.pix_out         (pix_out)
	);

	`SSCR_ASSERT_NOW(a_fwd_col0, v_s1 && fwd_s1, c_s1 == '0)
	`SSCR_ASSERT_NOW(a_emit_interior, v_s1 && emit_s1,
		(c_s1 >= sscr_pkg::COL_W'(2)) && (r_s1 >= sscr_pkg::ROW_W'(2)))
	`SSCR_ASSERT_NEXT(a_s1_held, v_s1 && !adv1, v_s1 && $stable(c_s1) && $stable(px_s1))

endmodule

>>> tb/sv/tb_sharpen_stencil_rgb_core.sv
// Self-checking bench for the five-point RGB sharpen core: raster pixel streams in,
// sharpened interior pixels out, predicted by a scoreboard class and compared in order.
// Depends on sscr_pkg, sscr_stream_if and the sharpen_stencil_rgb_core RTL.
`timescale 1ns / 1ps

import sscr_pkg::*;

typedef struct packed {
	logic [31:0]      word;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
} sharp_px_t;

// Width actually used by the line counter
function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
	if (w < MIN_WIDTH) return MIN_WIDTH;
	if (w > MAX_EFF_W) return MAX_WIDTH;
	return w;
endfunction

class sharpen_scoreboard;
	bit [PIX_W-1:0]    line_mem [2*MAX_WIDTH];
	bit                line_known [2*MAX_WIDTH];
	bit [PIX_W-1:0]    win [3][3];
	int unsigned       col_cnt;
	int unsigned       row_cnt;
	bit [WEIGHT_W-1:0] cw_reg;
	bit [WEIGHT_W-1:0] nw_reg;
	bit [WIDTH_W-1:0]  width_reg;
	sharp_px_t         sharpened_q [$];
	int unsigned       errors;

	function new();
		cw_reg = CENTER_WEIGHT_RST;
		nw_reg = NEIGHBOR_WEIGHT_RST;
		width_reg = ACTIVE_WIDTH_RST;
		col_cnt = 0;
		row_cnt = 0;
		errors = 0;
	endfunction

	function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
		case (idx)
			REG_CENTER_WEIGHT:   cw_reg = value[WEIGHT_W-1:0];
			REG_NEIGHBOR_WEIGHT: nw_reg = value[WEIGHT_W-1:0];
			REG_ACTIVE_WIDTH:    width_reg = value[WIDTH_W-1:0];
			default: ;
		endcase
	endfunction

	// True when both line memories hold defined data for every column of width w
	function bit width_covered(logic [WIDTH_W-1:0] w);
		for (int unsigned i = 0; i < eff_width(w); i++)
			if (!line_known[i] || !line_known[MAX_WIDTH + i]) return 1'b0;
		return 1'b1;
	endfunction

	function int unsigned pending();
		return sharpened_q.size();
	endfunction

	function bit [CH_W-1:0] sharpen_channel(int unsigned sh);
		longint cwt = longint'($signed(cw_reg));
		longint nwt = longint'($signed(nw_reg));
		longint ctr = longint'(win[1][1][sh +: CH_W]);
		longint nsum;
		longint acc;
		nsum = longint'(win[0][1][sh +: CH_W]) + longint'(win[2][1][sh +: CH_W])
			+ longint'(win[1][0][sh +: CH_W]) + longint'(win[1][2][sh +: CH_W]);
		acc = cwt * ctr + nwt * nsum;
		if (acc < 0) return '0;
		acc = acc >>> WEIGHT_FRAC_BITS;
		if (acc > 255) return 8'hff;
		return acc[CH_W-1:0];
	endfunction

	function void note_pixel(logic [31:0] word, logic fs);
		bit [PIX_W-1:0] px = word[31:8];
		int unsigned    w = eff_width(width_reg);
		int unsigned    c;
		int unsigned    r;
		bit [PIX_W-1:0] up1;
		bit [PIX_W-1:0] up2;
		sharp_px_t      res;
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
		r = row_cnt;
		up1 = line_mem[c];
		up2 = line_mem[MAX_WIDTH + c];
		line_mem[MAX_WIDTH + c] = up1;
		line_mem[c] = px;
		line_known[MAX_WIDTH + c] = line_known[c];
		line_known[c] = 1'b1;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = px;
		if (r >= 2 && c >= 2) begin
			res.word = {sharpen_channel(16), sharpen_channel(8), sharpen_channel(0), ALPHA};
			res.col = COL_W'(c - 1);
			res.row = ROW_W'(r - 1);
			sharpened_q.push_back(res);
		end
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			if (row_cnt < ROW_MAX) row_cnt++;
		end
	endfunction

	function void flag_error(string msg);
		errors++;
		if (errors <= 10) $display("%s", msg);
	endfunction

	function void check_result(logic [31:0] word, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		sharp_px_t exp_px;
		if (sharpened_q.size() == 0) begin
			flag_error($sformatf("unexpected result word=%h col=%0d row=%0d", word, col, row));
			return;
		end
		exp_px = sharpened_q.pop_front();
		if (word !== exp_px.word || col !== exp_px.col || row !== exp_px.row)
			flag_error($sformatf("mismatch: expected word=%h col=%0d row=%0d, got word=%h col=%0d row=%0d",
				exp_px.word, exp_px.col, exp_px.row, word, col, row));
	endfunction
endclass

module tb_sharpen_stencil_rgb_core;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	sscr_in_if  pix_in_bus ();
	sscr_out_if pix_out_bus ();

	sharpen_scoreboard sb;
	bit                in_gaps;
	bit                out_stalls;
	int unsigned       sent_items;

	sharpen_stencil_rgb_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("** sharpen_stencil_rgb_core: FAILED **");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] edge_word(int unsigned i);
		case (i % 8)
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'hff00_0011;
			3: return 32'h00ff_0022;
			4: return 32'h0000_ff33;
			5: return 32'h8080_8044;
			6: return 32'h7f7f_7f55;
			default: return 32'h01fe_0266;
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] w = $urandom();
		if ($urandom_range(0, 3) == 0)
			for (int k = 1; k < 4; k++)
				case ($urandom_range(0, 2))
					0: w[8*k +: 8] = 8'h00;
					1: w[8*k +: 8] = 8'hff;
					default: ;
				endcase
		return w;
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight(bit center);
		int unsigned r = $urandom_range(0, 9);
		int          v;
		if (r == 0) return WEIGHT_W'($urandom());
		if (r == 1)
			case ($urandom_range(0, 2))
				0: return 16'h8000;
				1: return 16'h7fff;
				default: return 16'h0000;
			endcase
		// weights that keep most results off the clamp
		if (center) v = $urandom_range(2048, 28672);
		else v = int'($urandom_range(0, 7168)) - 6144;
		return WEIGHT_W'(v);
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_width();
		int unsigned r = $urandom_range(0, 9);
		if (r == 0) return WIDTH_W'($urandom_range(0, 2));
		if (r == 1) return WIDTH_W'($urandom_range(13, 48));
		return WIDTH_W'($urandom_range(3, 12));
	endfunction

	// Write lands at the edge where the access phase is sampled
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [31:0] word, input logic fs);
		int unsigned gap;
		gap = in_gaps ? idle_len() : 0;
		if (gap != 0) begin
			pix_in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_bus.valid       <= 1'b1;
		pix_in_bus.pixel_word  <= word;
		pix_in_bus.frame_start <= fs;
		do @(posedge clk); while (pix_in_bus.ready !== 1'b1);
		sb.note_pixel(word, fs);
		sent_items++;
	endtask

	task automatic send_run(input int unsigned count, input bit fs_first, input bit edge_vals,
		input int unsigned fs_noise);
		for (int unsigned i = 0; i < count; i++) begin
			logic [31:0] w;
			logic        fs;
			w = edge_vals ? edge_word(i) : pick_word();
			fs = (i == 0 && fs_first) || ($urandom_range(0, 99) < fs_noise);
			send_pixel(w, fs);
		end
	endtask

	// Idle long enough for pixels that produce no result to leave the pipeline
	task automatic wait_drained();
		pix_in_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_phase();
		logic [WIDTH_W-1:0] next_w;
		bit                 wr_w;
		bit                 cont;
		int unsigned        eff;
		int unsigned        count;
		next_w = sb.width_reg;
		wr_w = $urandom_range(0, 2) != 0;
		if (wr_w) next_w = pick_width();
		// continuing a frame is safe only where the line memories are already filled
		cont = ($urandom_range(0, 7) == 0) && sb.width_covered(next_w);
		case ($urandom_range(0, 3))
			0: begin in_gaps = 1'b0; out_stalls = 1'b0; end
			1: begin in_gaps = 1'b1; out_stalls = 1'b0; end
			2: begin in_gaps = 1'b0; out_stalls = 1'b1; end
			default: begin in_gaps = 1'b1; out_stalls = 1'b1; end
		endcase
		if ($urandom_range(0, 2) != 0) reg_write(REG_CENTER_WEIGHT, {16'h0, pick_weight(1'b1)});
		if ($urandom_range(0, 2) != 0) reg_write(REG_NEIGHBOR_WEIGHT, {16'h0, pick_weight(1'b0)});
		if (wr_w) reg_write(REG_ACTIVE_WIDTH, {20'h0, next_w});
		eff = eff_width(next_w);
		count = eff * $urandom_range(3, 7) + $urandom_range(0, eff - 1);
		if ($urandom_range(0, 9) == 0) count = $urandom_range(1, 2 * eff);
		if (count > 1650 - sent_items) count = 1650 - sent_items;
		send_run(count, !cont, 1'b0, 2);
		wait_drained();
	endtask

	// Output side backpressure
	initial begin
		int unsigned hold;
		hold = 0;
		pix_out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0 && out_stalls && $urandom_range(0, 2) == 0) hold = idle_len();
			if (hold != 0) begin
				hold--;
				pix_out_bus.ready <= 1'b0;
			end else begin
				pix_out_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && pix_out_bus.valid === 1'b1 && pix_out_bus.ready === 1'b1)
			sb.check_result(pix_out_bus.result_word, pix_out_bus.out_col, pix_out_bus.out_row);
	end

	initial begin
		sb = new();
		in_gaps = 1'b1;
		out_stalls = 1'b1;
		sent_items = 0;
		arst_n                 <= 1'b0;
		pix_in_bus.valid       <= 1'b0;
		pix_in_bus.pixel_word  <= '0;
		pix_in_bus.frame_start <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weights, width below the minimum
		reg_write(REG_ACTIVE_WIDTH, 32'd0);
		send_run(12, 1'b1, 1'b1, 0);
		wait_drained();
		// largest positive weights: saturates high
		reg_write(REG_CENTER_WEIGHT, 32'h0000_7fff);
		reg_write(REG_NEIGHBOR_WEIGHT, 32'h0000_7fff);
		reg_write(REG_ACTIVE_WIDTH, 32'd1);
		send_run(9, 1'b1, 1'b1, 0);
		wait_drained();
		// most negative weights: negative sums clamp to zero
		reg_write(REG_CENTER_WEIGHT, 32'h0000_8000);
		reg_write(REG_NEIGHBOR_WEIGHT, 32'h0000_8000);
		reg_write(REG_ACTIVE_WIDTH, 32'd2);
		send_run(9, 1'b1, 1'b1, 0);
		wait_drained();
		// unity pass-through, then shrink the line below the current column
		reg_write(REG_CENTER_WEIGHT, 32'h0000_1000);
		reg_write(REG_NEIGHBOR_WEIGHT, 32'h0000_0000);
		reg_write(REG_ACTIVE_WIDTH, 32'd6);
		send_run(22, 1'b1, 1'b1, 0);
		wait_drained();
		reg_write(REG_ACTIVE_WIDTH, 32'd3);
		send_run(4, 1'b0, 1'b1, 0);
		send_run(1, 1'b1, 1'b1, 0);
		send_run(8, 1'b0, 1'b0, 0);
		wait_drained();

		// register above the maximum: a long first line that must not wrap early
		in_gaps = 1'b0;
		out_stalls = 1'b0;
		reg_write(REG_CENTER_WEIGHT, 32'd20480);
		reg_write(REG_NEIGHBOR_WEIGHT, 32'h0000_f000);
		reg_write(REG_ACTIVE_WIDTH, 32'd4095);
		send_run(160, 1'b1, 1'b0, 0);
		wait_drained();

		while (sent_items < 1650) random_phase();
		wait_drained();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** sharpen_stencil_rgb_core: PASSED **");
		else
			$display("** sharpen_stencil_rgb_core: FAILED **");
		$finish;
	end

endmodule
